@@ rtl/bme_pkg.sv @@
package bme_pkg;

  localparam int unsigned PHASES = 3;

  localparam logic [2:0] CFG_EMF_CONSTANT       = 3'd0;
  localparam logic [2:0] CFG_WINDING_RESISTANCE = 3'd1;
  localparam logic [2:0] CFG_INVERSE_INDUCTANCE = 3'd2;
  localparam logic [2:0] CFG_CURRENT_LIMIT      = 3'd3;
  localparam logic [2:0] CFG_FRICTION_GAIN      = 3'd4;
  localparam logic [2:0] CFG_TIME_STEP          = 3'd5;

  typedef struct packed {
    logic [30:0] emf_constant;
    logic [30:0] winding_resistance;
    logic [30:0] inverse_inductance;
    logic [30:0] current_limit;
    logic [30:0] friction_gain;
    logic [31:0] time_step;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0]        speed;
    logic [PHASES-1:0][31:0]   volt;
    logic signed [31:0]        load;
    logic [PHASES-1:0]         emf_neg;
    logic                      still;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EMF, ST_DROP, ST_DIFF, ST_RATE, ST_RATEW, ST_DI, ST_NEXT,
    ST_PROD, ST_DIV, ST_DIVW, ST_FRIC, ST_TORQ
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

@@ rtl/bldc_motor_electrical_step.sv @@
// bldc motor electrical step, signed q16.16
// input channel (in_valid_i/in_ready_o) takes one request per motor step:
// rotor angle, speed, three phase voltages and load torque. a front stage
// works out the back-emf sector of each phase and places the request in a
// two-entry queue, so requests are taken while the back end is busy.
// the back end runs the phases one after another through one shared
// 33x33 multiplier and a radix-2 divider of 64 iterations for the torque
// term, skipped at zero speed. the back end takes one request at a time
// and pops another from the queue only once it is back in idle. the
// result waits in an output register on out_valid_o until out_ready_i;
// while it waits the back end holds its next finished result and the
// queue keeps accepting until full.
// configuration uses cfg_we_i, cfg_addr_i and cfg_wdata_i; the user must
// write it only while no request is in flight. the block does not enforce it.
// reset clears the queue, the output valid flag and the three phase
// currents, and loads the configuration defaults.
module bldc_motor_electrical_step
  import bme_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        rotor_angle_i,
  input  logic signed [31:0] rotor_speed_i,
  input  logic signed [31:0] volt_a_i,
  input  logic signed [31:0] volt_b_i,
  input  logic signed [31:0] volt_c_i,
  input  logic signed [31:0] load_torque_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] amps_a_o,
  output logic signed [31:0] amps_b_o,
  output logic signed [31:0] amps_c_o,
  output logic signed [31:0] emf_a_o,
  output logic signed [31:0] emf_b_o,
  output logic signed [31:0] emf_c_o,
  output logic signed [31:0] shaft_torque_o,
  output logic               zero_speed_o
);

  cfg_t  cfg_q;
  logic  item_valid, item_pop;
  item_t item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.emf_constant       <= 31'd65536;
      cfg_q.winding_resistance <= 31'd65536;
      cfg_q.inverse_inductance <= 31'd65536;
      cfg_q.current_limit      <= 31'd655360;
      cfg_q.friction_gain      <= 31'd0;
      cfg_q.time_step          <= 32'd42950;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_EMF_CONSTANT:       cfg_q.emf_constant       <= cfg_wdata_i[30:0];
        CFG_WINDING_RESISTANCE: cfg_q.winding_resistance <= cfg_wdata_i[30:0];
        CFG_INVERSE_INDUCTANCE: cfg_q.inverse_inductance <= cfg_wdata_i[30:0];
        CFG_CURRENT_LIMIT:      cfg_q.current_limit      <= cfg_wdata_i[30:0];
        CFG_FRICTION_GAIN:      cfg_q.friction_gain      <= cfg_wdata_i[30:0];
        CFG_TIME_STEP:          cfg_q.time_step          <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bme_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rotor_angle_i(rotor_angle_i),
    .rotor_speed_i(rotor_speed_i),
    .volt_a_i     (volt_a_i),
    .volt_b_i     (volt_b_i),
    .volt_c_i     (volt_c_i),
    .load_torque_i(load_torque_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  bme_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .amps_a_o      (amps_a_o),
    .amps_b_o      (amps_b_o),
    .amps_c_o      (amps_c_o),
    .emf_a_o       (emf_a_o),
    .emf_b_o       (emf_b_o),
    .emf_c_o       (emf_c_o),
    .shaft_torque_o(shaft_torque_o),
    .zero_speed_o  (zero_speed_o)
  );

endmodule

@@ rtl/bme_front.sv @@
module bme_front
  import bme_pkg::*;
#(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        rotor_angle_i,
  input  logic signed [31:0] rotor_speed_i,
  input  logic signed [31:0] volt_a_i,
  input  logic signed [31:0] volt_b_i,
  input  logic signed [31:0] volt_c_i,
  input  logic signed [31:0] load_torque_i,
  output logic               item_valid_o,
  output item_t              item_o,
  input  logic               item_pop_i
);

  localparam int unsigned QW = ANGLE_BITS + 3;
  localparam logic [QW-1:0] FULL = QW'(1) << ANGLE_BITS;

  logic [ANGLE_BITS-1:0] angle;
  logic [QW-1:0]         pos [PHASES];
  item_t                 item_d;
  item_t                 fifo_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            count_q;
  logic                  push;

  always_comb begin
    angle = ANGLE_BITS'({{(ANGLE_BITS > 16 ? ANGLE_BITS - 16 : 1){1'b0}}, rotor_angle_i});
    for (int p = 0; p < PHASES; p++) begin
      pos[p] = QW'(3) * QW'(angle) + QW'(p) * FULL;
      if (pos[p] >= QW'(3) * FULL) begin
        pos[p] = pos[p] - QW'(3) * FULL;
      end
      item_d.emf_neg[p] = (pos[p] >= FULL) && (pos[p] < QW'(2) * FULL);
    end
    item_d.speed   = rotor_speed_i;
    item_d.volt[0] = volt_a_i;
    item_d.volt[1] = volt_b_i;
    item_d.volt[2] = volt_c_i;
    item_d.load    = load_torque_i;
    item_d.still   = (rotor_speed_i == 32'sd0);
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(item_pop_i);
    end
  end

endmodule

@@ rtl/bme_div.sv @@
module bme_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, neg_q;
  logic [32:0] trial;
  logic        fits;

  assign trial  = {rem_q, quo_q[63]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i[63] ? 64'(-num_i) : 64'(num_i);
      den_q <= den_i[31] ? 32'(-den_i) : 32'(den_i);
      rem_q <= 32'd0;
      neg_q <= num_i[63] ^ den_i[31];
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      quo_q <= {quo_q[62:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/bme_back.sv @@
module bme_back
  import bme_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] amps_a_o,
  output logic signed [31:0] amps_b_o,
  output logic signed [31:0] amps_c_o,
  output logic signed [31:0] emf_a_o,
  output logic signed [31:0] emf_b_o,
  output logic signed [31:0] emf_c_o,
  output logic signed [31:0] shaft_torque_o,
  output logic               zero_speed_o
);

  state_e             state_q, state_d;
  item_t              item_q;
  logic [1:0]         p_q;
  logic signed [31:0] amps_q [PHASES];
  logic signed [31:0] emf_q [PHASES];
  logic signed [31:0] diff_q, rate_q;
  logic signed [65:0] sum_q;
  logic signed [65:0] mul_q;
  logic signed [32:0] op_a, op_b;
  logic               div_start, div_done;
  logic signed [63:0] div_quo;
  logic               out_load, last_phase;
  logic signed [65:0] emf_prod;
  logic signed [33:0] next_amps, lim;
  logic signed [67:0] torque_sum;

  logic signed [31:0] out_amps_q [PHASES];
  logic signed [31:0] out_emf_q [PHASES];
  logic signed [31:0] out_torque_q;
  logic               out_still_q, out_valid_q;

  assign last_phase = (p_q == 2'(PHASES - 1));

  bme_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (mul_q[63:0]),
    .den_i  (item_q.speed),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (item_valid_i) state_d = ST_EMF;
      ST_EMF:   state_d = ST_DROP;
      ST_DROP:  state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_RATE;
      ST_RATE:  state_d = ST_RATEW;
      ST_RATEW: state_d = ST_DI;
      ST_DI:    state_d = ST_NEXT;
      ST_NEXT:  state_d = ST_PROD;
      ST_PROD:  state_d = ST_DIV;
      ST_DIV: begin
        if (!item_q.still) begin
          state_d = ST_DIVW;
        end else if (last_phase) begin
          state_d = ST_FRIC;
        end else begin
          state_d = ST_EMF;
        end
      end
      ST_DIVW: begin
        if (div_done) state_d = last_phase ? ST_FRIC : ST_EMF;
      end
      ST_FRIC:  state_d = ST_TORQ;
      ST_TORQ:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop_o = (state_q == ST_IDLE) && item_valid_i;
    div_start  = (state_q == ST_DIV) && !item_q.still;
    out_load   = (state_q == ST_TORQ) && (!out_valid_q || out_ready_i);
    op_a = 33'sd0;
    op_b = 33'sd0;
    unique case (state_q)
      ST_EMF: begin
        op_a = $signed({2'b00, cfg_i.emf_constant});
        op_b = 33'(item_q.speed);
      end
      ST_DROP: begin
        op_a = 33'(amps_q[p_q]);
        op_b = $signed({2'b00, cfg_i.winding_resistance});
      end
      ST_RATE: begin
        op_a = 33'(diff_q);
        op_b = $signed({2'b00, cfg_i.inverse_inductance});
      end
      ST_DI: begin
        op_a = 33'(rate_q);
        op_b = $signed({1'b0, cfg_i.time_step});
      end
      ST_PROD: begin
        op_a = 33'(amps_q[p_q]);
        op_b = 33'(emf_q[p_q]);
      end
      ST_FRIC, ST_TORQ: begin
        op_a = $signed({2'b00, cfg_i.friction_gain});
        op_b = 33'(item_q.speed);
      end
      default: begin
        op_a = 33'sd0;
        op_b = 33'sd0;
      end
    endcase
  end

  always_comb begin
    emf_prod   = item_q.emf_neg[p_q] ? -mul_q : mul_q;
    lim        = $signed({3'b000, cfg_i.current_limit});
    next_amps  = 34'(amps_q[p_q]) + $signed(mul_q[65:32]);
    if (next_amps > lim) begin
      next_amps = lim;
    end else if (next_amps < -lim) begin
      next_amps = -lim;
    end
    torque_sum = 68'(sum_q) - 68'(mul_q >>> 16) - 68'(item_q.load);
  end

  always_ff @(posedge clk_i) begin
    mul_q <= op_a * op_b;
    unique case (state_q)
      ST_IDLE:  if (item_valid_i) item_q <= item_i;
      ST_DROP:  emf_q[p_q] <= sat32(68'(emf_prod >>> 16));
      ST_DIFF:  diff_q <= sat32(68'($signed(item_q.volt[p_q])) - 68'(mul_q >>> 16)
                                - 68'(emf_q[p_q]));
      ST_RATEW: rate_q <= sat32(68'(mul_q >>> 16));
      default: ;
    endcase
    if (out_load) begin
      out_amps_q   <= amps_q;
      out_emf_q    <= emf_q;
      out_torque_q <= sat32(torque_sum);
      out_still_q  <= item_q.still;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_q         <= 2'd0;
      sum_q       <= 66'sd0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
        amps_q[p] <= 32'sd0;
      end
    end else begin
      state_q <= state_d;
      if (item_pop_o) begin
        p_q   <= 2'd0;
        sum_q <= 66'sd0;
      end
      if (state_q == ST_NEXT) begin
        amps_q[p_q] <= next_amps[31:0];
      end
      if (state_q == ST_DIVW && div_done) begin
        sum_q <= sum_q + 66'(div_quo);
      end
      if ((state_q == ST_DIV && item_q.still) || (state_q == ST_DIVW && div_done)) begin
        p_q <= p_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign amps_a_o       = out_amps_q[0];
  assign amps_b_o       = out_amps_q[1];
  assign amps_c_o       = out_amps_q[2];
  assign emf_a_o        = out_emf_q[0];
  assign emf_b_o        = out_emf_q[1];
  assign emf_c_o        = out_emf_q[2];
  assign shaft_torque_o = out_torque_q;
  assign zero_speed_o   = out_still_q;

endmodule

@@ verif/bme_checker.sv @@
`timescale 1ns / 100ps

module bme_checker
  import bme_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [15:0]        rotor_angle_i,
  input  logic signed [31:0] rotor_speed_i,
  input  logic signed [31:0] volt_a_i,
  input  logic signed [31:0] volt_b_i,
  input  logic signed [31:0] volt_c_i,
  input  logic signed [31:0] load_torque_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] amps_a_i,
  input  logic signed [31:0] amps_b_i,
  input  logic signed [31:0] amps_c_i,
  input  logic signed [31:0] emf_a_i,
  input  logic signed [31:0] emf_b_i,
  input  logic signed [31:0] emf_c_i,
  input  logic signed [31:0] shaft_torque_i,
  input  logic               zero_speed_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam longint unsigned TURN = 64'd1 << 16;

  typedef struct packed {
    logic signed [PHASES-1:0][31:0] amps;
    logic signed [PHASES-1:0][31:0] emf;
    logic signed [31:0]             torque;
    logic                           still;
  } step_t;

  longint ke, res, inv_l, i_max, fric, dt;
  longint amps_q[PHASES];
  step_t  step_q[$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic step_t motor_step(logic [15:0] angle, logic signed [31:0] spd,
                                       logic signed [31:0] va, logic signed [31:0] vb,
                                       logic signed [31:0] vc, logic signed [31:0] ld);
    step_t  r;
    longint speed, prod, cur, diff, rate, nxt, e, sum, q;
    longint volt[PHASES];
    speed = longint'(spd);
    volt[0] = longint'(va);
    volt[1] = longint'(vb);
    volt[2] = longint'(vc);
    sum = 0;
    for (int p = 0; p < PHASES; p++) begin
      q = (3 * longint'(angle) + p * TURN) % (3 * TURN);
      prod = ke * speed;
      if (q >= TURN && q < 2 * TURN) prod = -prod;
      e = clip32(prod >>> 16);
      cur = amps_q[p];
      diff = clip32(volt[p] - ((cur * res) >>> 16) - e);
      rate = clip32((diff * inv_l) >>> 16);
      nxt = cur + ((rate * dt) >>> 32);
      if (nxt > i_max) nxt = i_max;
      else if (nxt < -i_max) nxt = -i_max;
      amps_q[p] = nxt;
      if (speed != 0) sum += (nxt * e) / speed;
      r.amps[p] = nxt[31:0];
      r.emf[p] = e[31:0];
    end
    r.torque = 32'(clip32(sum - ((fric * speed) >>> 16) - longint'(ld)));
    r.still = (speed == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    step_t want;
    if (!rst_ni) begin
      ke = 65536;
      res = 65536;
      inv_l = 65536;
      i_max = 655360;
      fric = 0;
      dt = 42950;
      for (int p = 0; p < PHASES; p++) amps_q[p] = 0;
      step_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (step_q.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, 32'd0);
        end else begin
          want = step_q.pop_front();
          if (amps_a_i !== want.amps[0]) report_mismatch("amps_a", amps_a_i, want.amps[0]);
          if (amps_b_i !== want.amps[1]) report_mismatch("amps_b", amps_b_i, want.amps[1]);
          if (amps_c_i !== want.amps[2]) report_mismatch("amps_c", amps_c_i, want.amps[2]);
          if (emf_a_i !== want.emf[0]) report_mismatch("emf_a", emf_a_i, want.emf[0]);
          if (emf_b_i !== want.emf[1]) report_mismatch("emf_b", emf_b_i, want.emf[1]);
          if (emf_c_i !== want.emf[2]) report_mismatch("emf_c", emf_c_i, want.emf[2]);
          if (shaft_torque_i !== want.torque)
            report_mismatch("shaft_torque", shaft_torque_i, want.torque);
          if (zero_speed_i !== want.still)
            report_mismatch("zero_speed", {31'd0, zero_speed_i}, {31'd0, want.still});
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_q.push_back(motor_step(rotor_angle_i, rotor_speed_i, volt_a_i, volt_b_i,
                                    volt_c_i, load_torque_i));
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_EMF_CONSTANT:       ke = longint'(cfg_wdata_i[30:0]);
          CFG_WINDING_RESISTANCE: res = longint'(cfg_wdata_i[30:0]);
          CFG_INVERSE_INDUCTANCE: inv_l = longint'(cfg_wdata_i[30:0]);
          CFG_CURRENT_LIMIT:      i_max = longint'(cfg_wdata_i[30:0]);
          CFG_FRICTION_GAIN:      fric = longint'(cfg_wdata_i[30:0]);
          CFG_TIME_STEP:          dt = longint'(cfg_wdata_i);
          default: ;
        endcase
      end
      pending_o = step_q.size();
    end
  end

endmodule

@@ verif/tb_bldc_motor_electrical_step.sv @@
`timescale 1ns / 100ps

module tb_bldc_motor_electrical_step;
  import bme_pkg::*;

  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int         CYCLE_LIMIT  = 4000000;
  localparam int         DRAIN_CYCLES = 600;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_addr;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        angle;
  logic signed [31:0] speed, va, vb, vc, load;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] amps_a, amps_b, amps_c, emf_a, emf_b, emf_c, torque;
  logic               still;
  int                 errors, pending, cycles;
  int                 send_idle, recv_idle;

  bldc_motor_electrical_step dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .rotor_angle_i(angle), .rotor_speed_i(speed),
    .volt_a_i(va), .volt_b_i(vb), .volt_c_i(vc), .load_torque_i(load),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .amps_a_o(amps_a), .amps_b_o(amps_b), .amps_c_o(amps_c),
    .emf_a_o(emf_a), .emf_b_o(emf_b), .emf_c_o(emf_c),
    .shaft_torque_o(torque), .zero_speed_o(still)
  );

  bme_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .rotor_angle_i(angle), .rotor_speed_i(speed),
    .volt_a_i(va), .volt_b_i(vb), .volt_c_i(vc), .load_torque_i(load),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .amps_a_i(amps_a), .amps_b_i(amps_b), .amps_c_i(amps_c),
    .emf_a_i(emf_a), .emf_b_i(emf_b), .emf_c_i(emf_c),
    .shaft_torque_i(torque), .zero_speed_i(still),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send(logic [15:0] a, logic [31:0] s, logic [31:0] x, logic [31:0] y,
                      logic [31:0] z, logic [31:0] l);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    angle = a;
    speed = s;
    va = x;
    vb = y;
    vc = z;
    load = l;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h00200000) - 32'h00100000;
      2: return $urandom_range(32'h00020000) - 32'h00010000;
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic logic [31:0] pick_speed();
    if ($urandom_range(7) == 0) return 32'd0;
    return pick_value();
  endfunction

  task automatic random_run(int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      send(16'($urandom()), pick_speed(), pick_value(), pick_value(), pick_value(),
           pick_value());
    end
    in_valid = 1'b0;
  endtask

  initial begin
    logic [15:0] angles[6];
    angles = '{16'd0, 16'd21845, 16'd21846, 16'd43690, 16'd43691, 16'd65535};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    angle = '0;
    speed = '0;
    va = '0;
    vb = '0;
    vc = '0;
    load = '0;
    cycles = 0;
    send_idle = 32;
    recv_idle = 64;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: sector edges, zero and extreme speed, saturating fields
    foreach (angles[k]) send(angles[k], 32'h00010000, 32'h000c0000, 32'hfff40000,
                             32'h0, 32'h0);
    send(16'd100, 32'd0, 32'h00050000, 32'h00050000, 32'h00050000, 32'h00010000);
    send(16'd100, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h0, 32'h7fffffff);
    send(16'd40000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    send(16'd5, 32'd1, 32'h00010000, 32'h0, 32'hffff0000, 32'h0);
    send(16'd5, 32'hffffffff, 32'h00010000, 32'h0, 32'hffff0000, 32'hffffffff);
    in_valid = 1'b0;
    drain();
    cfg_write(CFG_EMF_CONSTANT, 32'hffffffff);
    cfg_write(CFG_WINDING_RESISTANCE, 32'h7fffffff);
    cfg_write(CFG_INVERSE_INDUCTANCE, 32'h7fffffff);
    cfg_write(CFG_CURRENT_LIMIT, 32'h7fffffff);
    cfg_write(CFG_FRICTION_GAIN, 32'h7fffffff);
    cfg_write(CFG_TIME_STEP, 32'hffffffff);
    cfg_write(CFG_SPARE_LO, 32'h12345678);
    cfg_write(CFG_SPARE_HI, 32'h0);
    send(16'd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0);
    send(16'd30000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
    send(16'd50000, 32'd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h0);
    send(16'd60000, 32'd1, 32'h1, 32'h80000000, 32'h7fffffff, 32'h0);
    in_valid = 1'b0;
    drain();
    cfg_write(CFG_EMF_CONSTANT, 32'h0);
    cfg_write(CFG_WINDING_RESISTANCE, 32'h0);
    cfg_write(CFG_INVERSE_INDUCTANCE, 32'h0);
    cfg_write(CFG_CURRENT_LIMIT, 32'h0);
    cfg_write(CFG_FRICTION_GAIN, 32'h0);
    cfg_write(CFG_TIME_STEP, 32'h0);
    send(16'd1, 32'h00020000, 32'h00050000, 32'h0, 32'h0, 32'h00030000);
    send(16'd2, 32'd0, 32'h80000000, 32'h0, 32'h0, 32'h80000000);
    in_valid = 1'b0;
    drain();

    // moderate plant with realistic gains
    cfg_write(CFG_EMF_CONSTANT, 32'h00008000 | $urandom_range(32'h0000ffff));
    cfg_write(CFG_WINDING_RESISTANCE, $urandom_range(32'h00040000));
    cfg_write(CFG_INVERSE_INDUCTANCE, 32'h00100000 + $urandom_range(32'h00ffffff));
    cfg_write(CFG_CURRENT_LIMIT, 32'h00140000);
    cfg_write(CFG_FRICTION_GAIN, $urandom_range(32'h00001000));
    cfg_write(CFG_TIME_STEP, 32'h00100000 + $urandom_range(32'h0fffffff));
    random_run(500);
    drain();

    send_idle = 64;
    recv_idle = 32;
    cfg_write(CFG_EMF_CONSTANT, $urandom());
    cfg_write(CFG_WINDING_RESISTANCE, $urandom());
    cfg_write(CFG_INVERSE_INDUCTANCE, $urandom());
    cfg_write(CFG_CURRENT_LIMIT, $urandom());
    cfg_write(CFG_FRICTION_GAIN, $urandom());
    cfg_write(CFG_TIME_STEP, $urandom());
    random_run(500);
    drain();

    send_idle = 0;
    recv_idle = 0;
    cfg_write(CFG_EMF_CONSTANT, 32'h00010000);
    cfg_write(CFG_WINDING_RESISTANCE, 32'h00008000);
    cfg_write(CFG_INVERSE_INDUCTANCE, 32'h7fffffff);
    cfg_write(CFG_CURRENT_LIMIT, 32'h7fffffff);
    cfg_write(CFG_FRICTION_GAIN, 32'h00000100);
    cfg_write(CFG_TIME_STEP, 32'hffffffff);
    random_run(500);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
